FILE: rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

	localparam int DIV_STEPS = 25;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		REG_KP             = 3'd0,
		REG_KI             = 3'd1,
		REG_KD             = 3'd2,
		REG_SAMPLE_PERIOD  = 3'd3,
		REG_ERR_LIMIT      = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5,
		REG_RATE_LIMIT     = 3'd6,
		REG_CMD_LIMIT      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] kp;
		logic signed [31:0] ki;
		logic signed [31:0] kd;
		logic [30:0]        sp;
		logic [30:0]        elim;
		logic [30:0]        ilim;
		logic [30:0]        rlim;
		logic [30:0]        clim;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_ACC_P,
		S_MUL_S,
		S_INT,
		S_MUL_I,
		S_ACC_I,
		S_DIV_INIT,
		S_DIV,
		S_RATE,
		S_MUL_D,
		S_ACC_D,
		S_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_P,
		OP_ACC_P,
		OP_MUL_S,
		OP_INT,
		OP_MUL_I,
		OP_ACC_I,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_RATE,
		OP_MUL_D,
		OP_ACC_D,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
			input logic [30:0] lim);
		logic signed [33:0] l;
		l = $signed({3'b000, lim});
		if (v > l) begin
			return l;
		end else if (v < -l) begin
			return -l;
		end else begin
			return v;
		end
	endfunction

	// Floor shift of a Q16.16 product by 16, saturated to 32 bits.
	function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
		logic [47:0] s;
		s = p[63:16];
		if (!s[47] && (s[46:31] != 16'h0000)) begin
			return 32'sh7FFF_FFFF;
		end else if (s[47] && (s[46:31] != 16'hFFFF)) begin
			return 32'sh8000_0000;
		end else begin
			return $signed(s[31:0]);
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pcc_regs.sv
`default_nettype none

module pcc_regs import pcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= 32'sd65536;
			cfg_q.ki   <= 32'sd6554;
			cfg_q.kd   <= 32'sd3277;
			cfg_q.sp   <= 31'd3277;
			cfg_q.elim <= 31'd65536;
			cfg_q.ilim <= 31'd65536;
			cfg_q.rlim <= 31'd13107;
			cfg_q.clim <= 31'd65536;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KP:             cfg_q.kp   <= $signed(cfg_wdata);
				REG_KI:             cfg_q.ki   <= $signed(cfg_wdata);
				REG_KD:             cfg_q.kd   <= $signed(cfg_wdata);
				REG_SAMPLE_PERIOD:  cfg_q.sp   <= cfg_wdata[30:0];
				REG_ERR_LIMIT:      cfg_q.elim <= cfg_wdata[30:0];
				REG_INTEGRAL_LIMIT: cfg_q.ilim <= cfg_wdata[30:0];
				REG_RATE_LIMIT:     cfg_q.rlim <= cfg_wdata[30:0];
				REG_CMD_LIMIT:      cfg_q.clim <= cfg_wdata[30:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/pcc_ctrl.sv
`default_nettype none

module pcc_ctrl import pcc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic kind,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd,
	input  sts_t      sts
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = kind ? S_IDLE : S_MUL_P;
				end
			end
			S_MUL_P:    state_d = S_ACC_P;
			S_ACC_P:    state_d = S_MUL_S;
			S_MUL_S:    state_d = S_INT;
			S_INT:      state_d = S_MUL_I;
			S_MUL_I:    state_d = S_ACC_I;
			S_ACC_I:    state_d = S_DIV_INIT;
			S_DIV_INIT: state_d = S_DIV;
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_RATE;
				end
			end
			S_RATE:     state_d = S_MUL_D;
			S_MUL_D:    state_d = S_ACC_D;
			S_ACC_D:    state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.op   = in_valid ? OP_LOAD : OP_NONE;
			end
			S_MUL_P:    cmd.op = OP_MUL_P;
			S_ACC_P:    cmd.op = OP_ACC_P;
			S_MUL_S:    cmd.op = OP_MUL_S;
			S_INT:      cmd.op = OP_INT;
			S_MUL_I:    cmd.op = OP_MUL_I;
			S_ACC_I:    cmd.op = OP_ACC_I;
			S_DIV_INIT: cmd.op = OP_DIV_INIT;
			S_DIV:      cmd.op = OP_DIV_STEP;
			S_RATE:     cmd.op = OP_RATE;
			S_MUL_D:    cmd.op = OP_MUL_D;
			S_ACC_D:    cmd.op = OP_ACC_D;
			S_FINISH:   cmd.op = out_free ? OP_FINISH : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/pcc_dpath.sv
`default_nettype none

module pcc_dpath import pcc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  cfg_t                    cfg,
	input  wire logic               kind,
	input  wire logic signed [31:0] reference,
	input  wire logic signed [31:0] measured,
	input  wire logic signed [31:0] restart_error,
	output logic signed [31:0]      command,
	output logic                    saturated
);

	logic signed [31:0] integral_q;
	logic signed [31:0] prev_q;
	logic [CNT_W-1:0]   cnt_q;

	logic signed [31:0] err_q;
	logic signed [63:0] prod_q;
	logic signed [33:0] acc_q;
	logic signed [31:0] rate_q;
	logic [30:0]        rem_q;
	logic [49:0]        quo_q;
	logic               neg_q;
	logic               zero_q;
	logic signed [31:0] command_q;
	logic               sat_q;

	logic signed [32:0] err_raw;
	logic signed [33:0] err_clamp;
	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [63:0] mul_p;
	logic signed [31:0] pterm;
	logic signed [33:0] pterm34;
	logic signed [33:0] isum;
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic [31:0]        t1;
	logic [31:0]        r1;
	logic [31:0]        t2;
	logic [31:0]        r2;
	logic               ge1;
	logic               ge2;
	logic [30:0]        rate_mag;
	logic signed [33:0] cmd_clamp;

	assign err_raw   = {reference[31], reference} - {measured[31], measured};
	assign err_clamp = clamp34({err_raw[32], err_raw}, cfg.elim);

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.op)
			OP_MUL_P: begin
				op_a = cfg.kp;
				op_b = err_q;
			end
			OP_MUL_S: begin
				op_a = err_q;
				op_b = $signed({1'b0, cfg.sp});
			end
			OP_MUL_I: begin
				op_a = cfg.ki;
				op_b = integral_q;
			end
			OP_MUL_D: begin
				op_a = cfg.kd;
				op_b = rate_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_p   = op_a * op_b;
	assign pterm   = qsat(prod_q);
	assign pterm34 = {{2{pterm[31]}}, pterm};
	assign isum    = clamp34({{2{integral_q[31]}}, integral_q} + pterm34, cfg.ilim);

	assign diff     = {err_q[31], err_q} - {prev_q[31], prev_q};
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

	// Two restoring division steps per cycle.
	assign t1  = {rem_q, quo_q[49]};
	assign ge1 = t1 >= {1'b0, cfg.sp};
	assign r1  = ge1 ? (t1 - {1'b0, cfg.sp}) : t1;
	assign t2  = {r1[30:0], quo_q[48]};
	assign ge2 = t2 >= {1'b0, cfg.sp};
	assign r2  = ge2 ? (t2 - {1'b0, cfg.sp}) : t2;

	assign rate_mag  = (quo_q > {19'd0, cfg.rlim}) ? cfg.rlim : quo_q[30:0];
	assign cmd_clamp = clamp34(acc_q, cfg.clim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_q     <= '0;
			cnt_q      <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					if (kind) begin
						integral_q <= '0;
						prev_q     <= restart_error;
					end
				end
				OP_INT:      integral_q <= isum[31:0];
				OP_DIV_INIT: begin
					prev_q <= err_q;
					cnt_q  <= '0;
				end
				OP_DIV_STEP: cnt_q <= cnt_q + CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD:     err_q <= err_clamp[31:0];
			OP_MUL_P,
			OP_MUL_S,
			OP_MUL_I,
			OP_MUL_D:    prod_q <= mul_p;
			OP_ACC_P:    acc_q <= pterm34;
			OP_ACC_I,
			OP_ACC_D:    acc_q <= acc_q + pterm34;
			OP_DIV_INIT: begin
				quo_q  <= {1'b0, diff_mag, 16'h0000};
				rem_q  <= '0;
				neg_q  <= diff[32];
				zero_q <= (diff == 33'sd0);
			end
			OP_DIV_STEP: begin
				quo_q <= {quo_q[47:0], ge1, ge2};
				rem_q <= r2[30:0];
			end
			OP_RATE: begin
				if (zero_q) begin
					rate_q <= '0;
				end else if (neg_q) begin
					rate_q <= -$signed({1'b0, rate_mag});
				end else begin
					rate_q <= $signed({1'b0, rate_mag});
				end
			end
			OP_FINISH: begin
				command_q <= cmd_clamp[31:0];
				sat_q     <= (cmd_clamp != acc_q);
			end
			default: begin
			end
		endcase
	end

	assign sts.div_done = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign command      = command_q;
	assign saturated    = sat_q;

endmodule

`default_nettype wire

FILE: rtl/pid_controller_clamped_unit.sv
// PID controller with clamped error, integral, error rate and command, all in
// signed Q16.16. A control sample is accepted only while the unit is idle. The
// clamped error is registered at acceptance. Sequencing steps then run around
// a single shared 32x32 multiplier that is used four times, and the radix-4
// divider divides the error change by the sample period. A sample holds the
// unit longer while the previous result still waits to be taken. A restart
// request gives no result. The result sits in an output register, so the next
// sample is accepted while an earlier result still waits to be taken.
`default_nettype none

module pid_controller_clamped_unit import pcc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic signed [31:0] reference,
	input  wire logic signed [31:0] measured,
	input  wire logic signed [31:0] restart_error,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      command,
	output logic                    saturated
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	pcc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pcc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg),
		.kind          (kind),
		.reference     (reference),
		.measured      (measured),
		.restart_error (restart_error),
		.command       (command),
		.saturated     (saturated)
	);

	logic signed [31:0] clim32;

	assign clim32 = $signed({1'b0, cfg.clim});

	a_restart_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind) |=> !$rose(out_valid))
		else $error("restart request produced a result");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !kind) |=> !in_ready)
		else $error("unit accepted a request while a sample is in progress");

	a_saturated_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (command == clim32 || command == -clim32))
		else $error("saturated command is not at the command limit");

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import pcc_pkg::*;

	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int SETTLE_CYCLES = 50;

	typedef struct {
		logic signed [31:0] command;
		logic               saturated;
	} drive_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               kind;
	logic signed [31:0] reference;
	logic signed [31:0] measured;
	logic signed [31:0] restart_error;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] command;
	logic               saturated;

	cfg_t          pid_cfg;
	longint        integ_state;
	longint        last_err;
	drive_result_t expected_drive[$];
	drive_result_t want;
	int            mismatches = 0;
	bit            tx_idle_en = 1'b1;
	bit            rx_idle_en = 1'b1;
	int            rx_hold = 0;
	int            rx_gap = 0;

	pid_controller_clamped_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint bound(input longint v, input longint lim);
		if (v > lim) begin
			return lim;
		end else if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	function automatic longint q_product(input longint a, input longint b);
		longint s;
		s = (a * b) >>> 16;
		if (s > SAT_HI) begin
			return SAT_HI;
		end else if (s < SAT_LO) begin
			return SAT_LO;
		end
		return s;
	endfunction

	function automatic void reset_pid_model();
		pid_cfg.kp   = 32'sd65536;
		pid_cfg.ki   = 32'sd6554;
		pid_cfg.kd   = 32'sd3277;
		pid_cfg.sp   = 31'd3277;
		pid_cfg.elim = 31'd65536;
		pid_cfg.ilim = 31'd65536;
		pid_cfg.rlim = 31'd13107;
		pid_cfg.clim = 31'd65536;
		integ_state  = 0;
		last_err     = 0;
	endfunction

	function automatic void predict_command(input logic signed [31:0] setpoint,
			input logic signed [31:0] plant);
		longint e, up, ui, ud, diff, rate, total, clamped, lim_r;
		drive_result_t r;
		e = bound(longint'(setpoint) - longint'(plant), longint'(pid_cfg.elim));
		up = q_product($signed(pid_cfg.kp), e);
		integ_state = bound(integ_state + q_product(e, longint'(pid_cfg.sp)),
			longint'(pid_cfg.ilim));
		ui = q_product($signed(pid_cfg.ki), integ_state);
		diff = e - last_err;
		lim_r = longint'(pid_cfg.rlim);
		if (pid_cfg.sp == 0) begin
			rate = (diff > 0) ? lim_r : ((diff < 0) ? -lim_r : 0);
		end else begin
			rate = bound((diff * 65536) / longint'(pid_cfg.sp), lim_r);
		end
		ud = q_product($signed(pid_cfg.kd), rate);
		last_err = e;
		total = up + ui + ud;
		clamped = bound(total, longint'(pid_cfg.clim));
		r.command = clamped[31:0];
		r.saturated = (clamped != total);
		expected_drive.push_back(r);
	endfunction

	// Output side: random stall bursts, plus a long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready = 1'b0;
				rx_hold--;
			end else if (rx_gap > 0) begin
				out_ready = 1'b0;
				rx_gap--;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				rx_gap = $urandom_range(0, 8);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_drive.size() == 0) begin
				$error("unexpected result: command %0d saturated %0b", command, saturated);
				mismatches++;
			end else begin
				want = expected_drive.pop_front();
				if (command !== want.command) begin
					$error("command: expected %0d, got %0d", want.command, command);
					mismatches++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated, saturated);
					mismatches++;
				end
			end
		end
	end

	task automatic offer_request(input logic k, input logic signed [31:0] setpoint,
			input logic signed [31:0] plant, input logic signed [31:0] new_err);
		int gap;
		gap = 0;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		kind = k;
		reference = setpoint;
		measured = plant;
		restart_error = new_err;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (k) begin
			integ_state = 0;
			last_err = longint'(new_err);
		end else begin
			predict_command(setpoint, plant);
		end
	endtask

	task automatic offer_sample(input logic signed [31:0] setpoint,
			input logic signed [31:0] plant);
		offer_request(1'b0, setpoint, plant, $urandom());
	endtask

	task automatic offer_restart(input logic signed [31:0] new_err);
		offer_request(1'b1, $urandom(), $urandom(), new_err);
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_drive.size() != 0) @(posedge clk);
	endtask

	// A restart leaves no result behind, so give the unit its full latency.
	task automatic settle_idle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			REG_KP:             pid_cfg.kp = val;
			REG_KI:             pid_cfg.ki = val;
			REG_KD:             pid_cfg.kd = val;
			REG_SAMPLE_PERIOD:  pid_cfg.sp = val[30:0];
			REG_ERR_LIMIT:      pid_cfg.elim = val[30:0];
			REG_INTEGRAL_LIMIT: pid_cfg.ilim = val[30:0];
			REG_RATE_LIMIT:     pid_cfg.rlim = val[30:0];
			REG_CMD_LIMIT:      pid_cfg.clim = val[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2, 3: return $urandom();
			default: return $urandom_range(0, 1 << 19) - (1 << 18);
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 6))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return 32'd0;
			3: return $urandom();
			default: return $urandom_range(0, 1 << 19) - (1 << 18);
		endcase
	endfunction

	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom();
			default: return $urandom_range(1, 1 << 17) | ($urandom() & 32'h8000_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_bound();
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(0, 1 << 18) | ($urandom() & 32'h8000_0000);
		endcase
	endfunction

	task automatic random_settings();
		reg_idx_t idx;
		logic [31:0] v;
		idx = idx.first();
		do begin
			case (idx)
				REG_KP, REG_KI, REG_KD: v = pick_gain();
				REG_SAMPLE_PERIOD:      v = pick_period();
				default:                v = pick_bound();
			endcase
			write_reg(idx, v);
			idx = idx.next();
		end while (idx != idx.first());
	endtask

	task automatic run_phase(input int count, input bit tx_idle, input bit rx_idle);
		logic signed [31:0] setpoint, plant;
		settle_idle();
		random_settings();
		tx_idle_en = tx_idle;
		rx_idle_en = rx_idle;
		repeat (count) begin
			if ($urandom_range(0, 7) == 0) begin
				offer_restart(pick_value());
			end else begin
				setpoint = pick_value();
				if ($urandom_range(0, 1) == 0) begin
					plant = setpoint - ($urandom_range(0, 1 << 17) - (1 << 16));
				end else begin
					plant = pick_value();
				end
				offer_sample(setpoint, plant);
			end
		end
	endtask

	task automatic test_reset_defaults();
		offer_sample(0, 0);
		offer_sample(Q_ONE, 0);
		offer_sample(0, Q_ONE / 2);
		offer_sample(Q_MAX, Q_MIN);
		offer_sample(Q_MIN, Q_MAX);
		offer_sample(Q_MIN, Q_MIN);
		offer_restart(Q_MIN);
		offer_sample(0, 0);
		offer_restart(Q_MAX);
		offer_sample(Q_MAX, 0);
		offer_restart(0);
		offer_sample(32'shFFFF_8000, Q_ONE);
	endtask

	task automatic test_special_settings();
		settle_idle();
		write_reg(REG_SAMPLE_PERIOD, 32'd0);
		offer_sample(Q_ONE, 0);
		offer_sample(Q_ONE, 0);
		offer_sample(0, Q_ONE);
		settle_idle();
		write_reg(REG_SAMPLE_PERIOD, 32'd3277);
		write_reg(REG_INTEGRAL_LIMIT, 32'd0);
		write_reg(REG_RATE_LIMIT, 32'd0);
		write_reg(REG_CMD_LIMIT, 32'd0);
		offer_sample(Q_ONE, 0);
		offer_sample(Q_MIN, Q_MAX);
		settle_idle();
		write_reg(REG_ERR_LIMIT, 32'd0);
		offer_sample(Q_MAX, Q_MIN);
		settle_idle();
		write_reg(REG_KP, Q_MIN);
		write_reg(REG_KI, Q_MIN);
		write_reg(REG_KD, Q_MIN);
		write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
		write_reg(REG_ERR_LIMIT, 32'h7FFF_FFFF);
		write_reg(REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_RATE_LIMIT, 32'h7FFF_FFFF);
		write_reg(REG_CMD_LIMIT, 32'hFFFF_FFFF);
		offer_sample(Q_MAX, Q_MIN);
		offer_sample(Q_MIN, Q_MAX);
		offer_restart(Q_MIN);
		offer_sample(Q_MAX, Q_MIN);
		settle_idle();
		write_reg(REG_KP, Q_MAX);
		write_reg(REG_KI, Q_MAX);
		write_reg(REG_KD, Q_MAX);
		write_reg(REG_SAMPLE_PERIOD, 32'd1);
		offer_sample(Q_MAX, Q_MIN);
		offer_sample(Q_MIN, Q_MAX);
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 24; p++) begin
			run_phase(50, (p % 3) != 2, (p % 3) != 1);
		end
	endtask

	task automatic test_output_stall();
		settle_idle();
		random_settings();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		rx_hold = 400;
		repeat (30) offer_sample(pick_value(), pick_value());
	endtask

	task automatic test_sender_pause();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (15) offer_sample(pick_value(), pick_value());
		wait_results();
		repeat (15) offer_sample(pick_value(), pick_value());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KP;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		reference = '0;
		measured = '0;
		restart_error = '0;
		reset_pid_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_special_settings();
		test_random_phases();
		test_output_stall();
		test_sender_pause();
		run_phase(450, 1'b0, 1'b0);

		settle_idle();
		if (mismatches == 0 && expected_drive.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: pid_controller_clamped_unit.f
rtl/pcc_pkg.sv
rtl/pcc_regs.sv
rtl/pcc_ctrl.sv
rtl/pcc_dpath.sv
rtl/pid_controller_clamped_unit.sv
test/tb.sv
